### rtl/core/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Types, constants and the slew step shared by the servo pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int CHANNEL_COUNT = 8;
  localparam int CH_W          = $clog2(CHANNEL_COUNT);
  localparam int POS_W         = 8;

  // Request codes
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Channels with their own start-phase rules
  localparam logic [CH_W-1:0] CH_RAW    = CH_W'(4);
  localparam logic [CH_W-1:0] CH_SLOW   = CH_W'(5);

  // Reload constants
  localparam logic [POS_W-1:0] RELOAD_SLOW = 8'd140;
  localparam logic [POS_W-1:0] RELOAD_RAW  = 8'd150;
  localparam logic [POS_W-1:0] RELOAD_BASE = 8'd120;
  localparam logic [POS_W-1:0] POS_MAX     = 8'd255;

  // Slew settings: step, snap band, far limit
  localparam logic [POS_W-1:0] STEP_FAST = 8'd4;
  localparam logic [POS_W-1:0] SNAP_FAST = 8'd3;
  localparam logic [POS_W-1:0] FAR_FAST  = 8'd8;
  localparam logic [POS_W-1:0] STEP_SLOW = 8'd3;
  localparam logic [POS_W-1:0] SNAP_SLOW = 8'd2;
  localparam logic [POS_W-1:0] FAR_SLOW  = 8'd6;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_HOLD  = 2'd1,
    PH_END   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [POS_W-1:0] pin_levels;
    logic [POS_W-1:0] timer_reload;
    logic             reload_valid;
    logic [CH_W-1:0]  active_channel;
  } result_t;

  // New commanded position after one slot of slew toward the target
  function automatic logic [POS_W-1:0] slew_step(
    input logic [POS_W-1:0] cur,
    input logic [POS_W-1:0] tgt,
    input logic [POS_W-1:0] step,
    input logic [POS_W-1:0] snap,
    input logic [POS_W-1:0] far_lim
  );
    logic [POS_W-1:0] d;
    logic [POS_W-1:0] mv;
    logic [POS_W-1:0] res;
    d  = (cur > tgt) ? (cur - tgt) : (tgt - cur);
    mv = (d > far_lim) ? step : (d >> 1);
    if (cur == '0) begin
      res = tgt;
    end else if (tgt == '0) begin
      res = cur;
    end else if (d < snap) begin
      res = tgt;
    end else if (cur > tgt) begin
      res = cur - mv;
    end else begin
      res = cur + mv;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/servo_pulse_sequencer_unit.sv
// ----------------------------------------------------------------------------
// servo_pulse_sequencer_unit
// Eight-channel round-robin servo pulse sequencer: one slot per channel,
// start / hold / end phases, slew-limited positions and masked pin drive.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, req_type,              | input
//          | channel_index, target_value               |
//  out     | out_valid/out_ready, pin_levels,          | output
//          | timer_reload, reload_valid, active_channel|
//  cfg     | cfg_we, cfg_data (channel_mask)           | input
//
//  One beat per cycle in while in_ready is high, one result beat per input beat; results are registered.
//  All step logic sits between the accept edge and the result register.
//  A skid register keeps input open for one beat while out_ready is low.
//  rst (synchronous) clears state, targets, positions, pins; mask = 0xFF.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_pulse_sequencer_unit
  import sps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [POS_W-1:0]  cfg_data,
  // request beats
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              req_type,
  input  wire logic [CH_W-1:0]   channel_index,
  input  wire logic [POS_W-1:0]  target_value,
  // result beats
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [POS_W-1:0]       pin_levels,
  output logic [POS_W-1:0]       timer_reload,
  output logic                   reload_valid,
  output logic [CH_W-1:0]        active_channel
);

  // State
  logic [POS_W-1:0] channel_mask;
  phase_t           phase, phase_next;
  logic [CH_W-1:0]  channel, channel_next;
  logic [POS_W-1:0] pulse_value, pulse_value_next;
  logic [POS_W-1:0] target_positions    [CHANNEL_COUNT];
  logic [POS_W-1:0] commanded_positions [CHANNEL_COUNT];
  logic [POS_W-1:0] pin_state, pin_state_next;

  // Output register and skid
  result_t out_reg, skid_reg, res_next;
  logic    skid_valid;

  logic in_fire, out_fire, is_tick;
  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign is_tick  = (req_type == REQ_TICK);

  // Current slot values
  logic [POS_W-1:0] cur_tgt, cur_cmd, cmd_new, start_pulse, start_reload;
  logic             ch_bit_en;
  assign cur_tgt   = target_positions[channel];
  assign cur_cmd   = commanded_positions[channel];
  assign ch_bit_en = channel_mask[channel];

  // Start-phase pulse and reload by channel
  always_comb begin
    if (channel == CH_SLOW) begin
      cmd_new      = slew_step(cur_cmd, cur_tgt, STEP_SLOW, SNAP_SLOW, FAR_SLOW);
      start_pulse  = (cur_tgt == '0) ? '0 : cmd_new;
      start_reload = RELOAD_SLOW;
    end else if (channel == CH_RAW) begin
      cmd_new      = cur_cmd;
      start_pulse  = cur_tgt;
      start_reload = RELOAD_RAW;
    end else begin
      cmd_new      = slew_step(cur_cmd, cur_tgt, STEP_FAST, SNAP_FAST, FAR_FAST);
      start_pulse  = (cur_tgt == '0) ? '0 : cmd_new;
      start_reload = RELOAD_BASE + ((POS_MAX - start_pulse) >> 2);
    end
  end

  // Next state
  always_comb begin
    phase_next       = phase;
    channel_next     = channel;
    pulse_value_next = pulse_value;
    pin_state_next   = pin_state;
    if (is_tick) begin
      unique case (phase)
        PH_START: begin
          pulse_value_next = start_pulse;
          if (start_pulse != '0 && ch_bit_en) begin
            pin_state_next[channel] = 1'b1;
          end
          phase_next = PH_HOLD;
        end
        PH_HOLD: begin
          phase_next = PH_END;
        end
        PH_END: begin
          if (ch_bit_en) begin
            pin_state_next[channel] = 1'b0;
          end
          channel_next = channel + 1'b1;
          phase_next   = PH_START;
        end
        default: begin
          phase_next = PH_START;
        end
      endcase
    end
  end

  // Result beat
  always_comb begin
    res_next.pin_levels     = pin_state_next;
    res_next.reload_valid   = is_tick;
    res_next.active_channel = channel_next;
    res_next.timer_reload   = '0;
    if (is_tick) begin
      unique case (phase)
        PH_START: res_next.timer_reload = start_reload;
        PH_HOLD:  res_next.timer_reload = POS_MAX - pulse_value;
        PH_END:   res_next.timer_reload = cur_tgt;
        default:  res_next.timer_reload = '0;
      endcase
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mask <= '1;
    end else if (cfg_we) begin
      channel_mask <= cfg_data;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      channel     <= '0;
      pulse_value <= '0;
      pin_state   <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        target_positions[i]    <= '0;
        commanded_positions[i] <= '0;
      end
    end else if (in_fire) begin
      phase       <= phase_next;
      channel     <= channel_next;
      pulse_value <= pulse_value_next;
      pin_state   <= pin_state_next;
      if (!is_tick) begin
        target_positions[channel_index] <= target_value;
      end else if (phase == PH_START) begin
        commanded_positions[channel] <= cmd_new;
      end
    end
  end

  // Output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_ready) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_valid && !out_ready) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_reg <= skid_reg;
      end
    end else if (in_fire) begin
      if (out_valid && !out_ready) begin
        skid_reg <= res_next;
      end else begin
        out_reg <= res_next;
      end
    end
  end

  assign pin_levels     = out_reg.pin_levels;
  assign timer_reload   = out_reg.timer_reload;
  assign reload_valid   = out_reg.reload_valid;
  assign active_channel = out_reg.active_channel;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output register is empty");

  a_write_no_reload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reload_valid) |-> (timer_reload == '0))
    else $error("write beat carries a nonzero reload");

  a_end_advances: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_tick && phase == PH_END) |=>
      (channel == CH_W'($past(channel) + 1'b1) && phase == PH_START))
    else $error("end phase did not advance the channel");

  a_masked_pins_hold: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (((pin_state ^ $past(pin_state)) & ~$past(channel_mask)) == '0))
    else $error("masked pin changed");

  a_write_keeps_slot: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_tick) |=> ($stable(phase) && $stable(channel) && $stable(pin_state)))
    else $error("target write disturbed the slot");

endmodule

`default_nettype wire

### sim/servo_pulse_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// servo_pulse_sequencer_unit_tb
// Self-checking bench for the eight-channel servo pulse sequencer. A short
// stimulus table covers reset values, extremes and the raw and slow channels.
// Random tick and target-write beats follow under several channel masks. Each
// request beat is run through a local model of the slot sequencer. Result beats
// are compared field by field, in order, with the queued predictions.
// ----------------------------------------------------------------------------
module servo_pulse_sequencer_unit_tb;
  import sps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BEATS    = 275;
  localparam int IDLE_PCT       = 12;

  // one row of the stimulus table; typed rows carry their own expectation
  typedef struct {
    logic             req;
    logic [CH_W-1:0]  ch;
    logic [POS_W-1:0] tv;
    bit               typed;
    result_t          want;
  } stim_row_t;

  localparam int TABLE_ROWS = 25;

  stim_row_t stim_table [TABLE_ROWS] = '{
    // channel 0 slot right after reset: everything zero
    '{REQ_TICK,  3'd0, 8'd0,   1'b1, '{8'h00, 8'd183, 1'b1, 3'd0}},
    '{REQ_TICK,  3'd0, 8'd0,   1'b1, '{8'h00, 8'd255, 1'b1, 3'd0}},
    '{REQ_TICK,  3'd0, 8'd0,   1'b1, '{8'h00, 8'd0,   1'b1, 3'd1}},
    // target writes, extremes of index and value
    '{REQ_WRITE, 3'd1, 8'd255, 1'b1, '{8'h00, 8'd0,   1'b0, 3'd1}},
    '{REQ_WRITE, 3'd5, 8'd200, 1'b1, '{8'h00, 8'd0,   1'b0, 3'd1}},
    '{REQ_WRITE, 3'd4, 8'd1,   1'b1, '{8'h00, 8'd0,   1'b0, 3'd1}},
    '{REQ_WRITE, 3'd7, 8'd0,   1'b1, '{8'h00, 8'd0,   1'b0, 3'd1}},
    // channel 1 takes full scale at once, then a write lands mid-slot
    '{REQ_TICK,  3'd7, 8'd255, 1'b1, '{8'h02, 8'd120, 1'b1, 3'd1}},
    '{REQ_WRITE, 3'd1, 8'd1,   1'b1, '{8'h02, 8'd0,   1'b0, 3'd1}},
    '{REQ_TICK,  3'd0, 8'd0,   1'b1, '{8'h02, 8'd0,   1'b1, 3'd1}},
    '{REQ_TICK,  3'd0, 8'd0,   1'b1, '{8'h00, 8'd1,   1'b1, 3'd2}},
    // channels 2..5 through one slot each
    '{REQ_WRITE, 3'd2, 8'd128, 1'b0, '0},
    '{REQ_TICK,  3'd0, 8'd0,   1'b0, '0},
    '{REQ_TICK,  3'd0, 8'd0,   1'b0, '0},
    '{REQ_TICK,  3'd0, 8'd0,   1'b0, '0},
    '{REQ_TICK,  3'd7, 8'd255, 1'b0, '0},
    '{REQ_TICK,  3'd7, 8'd255, 1'b0, '0},
    '{REQ_TICK,  3'd7, 8'd255, 1'b0, '0},
    '{REQ_TICK,  3'd0, 8'd0,   1'b0, '0},
    '{REQ_TICK,  3'd0, 8'd0,   1'b0, '0},
    '{REQ_TICK,  3'd0, 8'd0,   1'b0, '0},
    '{REQ_TICK,  3'd0, 8'd0,   1'b0, '0},
    '{REQ_TICK,  3'd0, 8'd0,   1'b0, '0},
    '{REQ_TICK,  3'd0, 8'd0,   1'b0, '0},
    '{REQ_WRITE, 3'd0, 8'd255, 1'b0, '0}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [POS_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             req_type = REQ_TICK;
  logic [CH_W-1:0]  channel_index = '0;
  logic [POS_W-1:0] target_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [POS_W-1:0] pin_levels;
  logic [POS_W-1:0] timer_reload;
  logic             reload_valid;
  logic [CH_W-1:0]  active_channel;

  // expectation attached to the beat on the wire
  bit               beat_typed = 1'b0;
  result_t          beat_want = '0;

  // sequencer model state
  logic [POS_W-1:0] mask_m;
  phase_t           phase_m;
  logic [CH_W-1:0]  chan_m;
  logic [POS_W-1:0] pulse_m;
  logic [POS_W-1:0] tgt_m [CHANNEL_COUNT];
  logic [POS_W-1:0] cmd_m [CHANNEL_COUNT];
  logic [POS_W-1:0] pins_m;

  result_t          pending_results [$];
  int               error_count = 0;
  int               stall_cycles = 0;
  bit               calm = 1'b0;

  servo_pulse_sequencer_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .channel_index  (channel_index),
    .target_value   (target_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pin_levels     (pin_levels),
    .timer_reload   (timer_reload),
    .reload_valid   (reload_valid),
    .active_channel (active_channel)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // one slot of slew for channel ch; updates the commanded position
  function automatic logic [POS_W-1:0] slew_position(input logic [CH_W-1:0] ch,
                                                     input int stepv, input int snapv,
                                                     input int farv);
    int cur;
    int tgt;
    int gap;
    int mv;
    cur = cmd_m[ch];
    tgt = tgt_m[ch];
    if (cur == 0) begin
      cmd_m[ch] = POS_W'(tgt);
      return POS_W'(tgt);
    end
    // disabled channel: pulse off, position held
    if (tgt == 0) return '0;
    gap = (cur > tgt) ? cur - tgt : tgt - cur;
    if (gap < snapv) mv = gap;
    else if (gap > farv) mv = stepv;
    else mv = gap >> 1;
    cur = (cur > tgt) ? cur - mv : cur + mv;
    cmd_m[ch] = POS_W'(cur);
    return POS_W'(cur);
  endfunction

  // advance the sequencer model by one request beat
  function automatic result_t sequence_beat(input logic rq, input logic [CH_W-1:0] ci,
                                            input logic [POS_W-1:0] tv);
    result_t          r;
    logic [CH_W-1:0]  ch;
    logic [POS_W-1:0] ch_bit;
    ch = chan_m;
    ch_bit = POS_W'(1) << ch;
    r = '0;
    if (rq == REQ_WRITE) begin
      tgt_m[ci] = tv;
    end else begin
      r.reload_valid = 1'b1;
      case (phase_m)
        PH_START: begin
          if (ch == CH_SLOW) begin
            pulse_m = slew_position(ch, STEP_SLOW, SNAP_SLOW, FAR_SLOW);
            r.timer_reload = RELOAD_SLOW;
          end else if (ch == CH_RAW) begin
            pulse_m = tgt_m[ch];
            r.timer_reload = RELOAD_RAW;
          end else begin
            pulse_m = slew_position(ch, STEP_FAST, SNAP_FAST, FAR_FAST);
            r.timer_reload = RELOAD_BASE + ((POS_MAX - pulse_m) >> 2);
          end
          if (pulse_m != '0 && (mask_m & ch_bit) != '0) pins_m = pins_m | ch_bit;
          phase_m = PH_HOLD;
        end
        PH_HOLD: begin
          r.timer_reload = POS_MAX - pulse_m;
          phase_m = PH_END;
        end
        default: begin
          if ((mask_m & ch_bit) != '0) pins_m = pins_m & ~ch_bit;
          r.timer_reload = tgt_m[ch];
          chan_m = ch + 1'b1;
          phase_m = PH_START;
        end
      endcase
    end
    r.pin_levels = pins_m;
    r.active_channel = chan_m;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // prediction on accepted request beats, checking on accepted result beats
  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst) begin
      mask_m = 8'hFF;
      phase_m = PH_START;
      chan_m = '0;
      pulse_m = '0;
      pins_m = '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        tgt_m[i] = '0;
        cmd_m[i] = '0;
      end
      pending_results.delete();
    end else begin
      if (cfg_we) mask_m = cfg_data;
      if (in_valid && in_ready) begin
        want = sequence_beat(req_type, channel_index, target_value);
        if (beat_typed) want = beat_want;
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual pins %02h reload %0d",
                   $time, pin_levels, timer_reload);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("pin_levels", want.pin_levels, pin_levels);
          check_field("timer_reload", want.timer_reload, timer_reload);
          check_field("reload_valid", want.reload_valid, reload_valid);
          check_field("active_channel", want.active_channel, active_channel);
        end
      end
    end
  end

  // result-side back-pressure
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // present one request beat and hold it until accepted
  task automatic send_beat(input logic rq, input logic [CH_W-1:0] ci,
                           input logic [POS_W-1:0] tv, input bit typed, input result_t want);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid      <= 1'b1;
    req_type      <= rq;
    channel_index <= ci;
    target_value  <= tv;
    beat_typed    <= typed;
    beat_want     <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and let every outstanding result drain
  task automatic drain_results();
    in_valid <= 1'b0;
    // wait for the scoreboard to queue the last accepted beat before the count is read
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_mask(input logic [POS_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // target near the current commanded position, to hit the slew bands
  function automatic logic [POS_W-1:0] target_near(input logic [CH_W-1:0] ch);
    int v;
    v = int'(cmd_m[ch]) + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 12));
    if (v < 1) v = 1;
    if (v > 255) v = 255;
    return POS_W'(v);
  endfunction

  initial begin : stimulus
    logic [POS_W-1:0] mask_plan [6];
    logic             rq;
    logic [CH_W-1:0]  ci;
    logic [POS_W-1:0] tv;
    int               sel;

    mask_plan = '{8'h00, 8'hFF, 8'h5A, 8'h00, 8'h00, 8'hFF};
    mask_plan[3] = POS_W'($urandom_range(0, 255));
    mask_plan[4] = POS_W'($urandom_range(0, 255));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < TABLE_ROWS; i++) begin
      send_beat(stim_table[i].req, stim_table[i].ch, stim_table[i].tv,
                stim_table[i].typed, stim_table[i].want);
    end

    // random phases, each under its own mask
    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_mask(mask_plan[p]);
      calm = (p == 2);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (k == PHASE_BEATS / 2) drain_results();
        sel = $urandom_range(0, 99);
        ci  = CH_W'($urandom_range(0, CHANNEL_COUNT - 1));
        tv  = POS_W'($urandom_range(0, 255));
        if (sel < 68) begin
          // tick; index and value are noise
          rq = REQ_TICK;
        end else begin
          rq = REQ_WRITE;
          if (sel < 78) ci = chan_m;
          case ($urandom_range(0, 9))
            0: tv = '0;
            1: tv = POS_MAX;
            2: tv = 8'd1;
            3, 4, 5, 6: tv = target_near(ci);
            default: ;
          endcase
        end
        send_beat(rq, ci, tv, 1'b0, '0);
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/sps_pkg.sv
rtl/core/servo_pulse_sequencer_unit.sv
sim/servo_pulse_sequencer_unit_tb.sv
